// ----- rtl/ptpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared types and constants for the sync client link block.
// ----------------------------------------------------------------------------
package ptpc_pkg;

  localparam int TICK_W = 32;
  localparam int CMP_W  = (TICK_W > 32) ? TICK_W : 32;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam logic [7:0] BRIGHT_RESET = 8'd40;
  localparam logic [7:0] PROG_RESET   = 8'd0;
  localparam logic [7:0] PAL_RESET    = 8'd0;

  // input command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_BCAST = 3'd1;
  localparam logic [2:0] CMD_SYNC  = 3'd2;
  localparam logic [2:0] CMD_DRESP = 3'd3;
  localparam logic [2:0] CMD_STATE = 3'd4;

  typedef enum logic [2:0] {
    KIND_ACK      = 3'd0,
    KIND_DREQ     = 3'd1,
    KIND_OFFSET   = 3'd2,
    KIND_STATE    = 3'd3,
    KIND_DISC     = 3'd4,
    KIND_MISMATCH = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_BCAST,
    OP_SYNC,
    OP_DRESP,
    OP_STATE
  } op_t;

  typedef enum logic {
    LINK_DOWN,
    LINK_UP
  } link_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [62:0] rx_time_us;
    logic [62:0] tx_time_us;
    logic [62:0] root_time_us;
    logic [31:0] in_sync_id;
    logic [7:0]  prog_num;
    logic [7:0]  pal_num;
    logic [7:0]  brightness;
    logic        flash_req;
    logic [7:0]  flash_red;
    logic [7:0]  flash_green;
    logic [7:0]  flash_blue;
  } in_item_t;

  typedef struct packed {
    kind_t              out_kind;
    logic [31:0]        req_sync_id;
    logic signed [63:0] offset_us;
    logic               link_up;
    logic [7:0]         show_program;
    logic [7:0]         show_palette;
    logic [7:0]         show_brightness;
    logic               show_flash;
    logic [7:0]         show_red;
    logic [7:0]         show_green;
    logic [7:0]         show_blue;
  } out_item_t;

  // classified event passed from front to back
  typedef struct packed {
    op_t         op;
    logic [62:0] rx;
    logic [62:0] tx;
    logic [62:0] rt;
    logic [31:0] id;
    logic [7:0]  prog_num;
    logic [7:0]  pal_num;
    logic [7:0]  brightness;
    logic        flash;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } ev_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic ready;
  } qctl_t;

endpackage
`default_nettype wire

// ----- rtl/ptpc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptpc_if
// Valid/ready channels for event items, result items and the timeout register.
// ----------------------------------------------------------------------------
interface ptpc_in_if;
  import ptpc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptpc_out_if;
  import ptpc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ptp_sync_client_link_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_sync_client_link_fsm
// Link and time-sync client that follows a root node.
//
//   channel  dir  contents
//   in_ch    in   event item: cmd, timestamps, sync id, state and flash fields
//   out_ch   out  result item: kind, delay request id, offset, applied state
//   cfg_ch   in   timeout_ticks write, always ready
//
// One item per cycle sustained while the output is not stalled. An item is
// written into the event queue at its accepting edge and executed from the queue
// head; its result is then registered in the result register. A stalled result
// holds the back part, and the input stalls once both queue entries are full.
// Reset (rst_n low, synchronous) drops the link and restores the defaults.
// ----------------------------------------------------------------------------
module ptp_sync_client_link_fsm (
  input  logic        clk,
  input  logic        rst_n,
  ptpc_in_if.sink     in_ch,
  ptpc_out_if.source  out_ch,
  ptpc_cfg_if.sink    cfg_ch
);
  import ptpc_pkg::*;

  ev_t   push_ev;
  ev_t   head_ev;
  logic  push;
  logic  full;
  logic  pop;
  qctl_t q_ctl;

  ptpc_front u_front (
    .in_ch   (in_ch),
    .ev      (push_ev),
    .ev_push (push),
    .q_full  (full)
  );

  ptpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_ev (push_ev),
    .push    (push),
    .full    (full),
    .head    (head_ev),
    .ctl     (q_ctl),
    .pop     (pop)
  );

  ptpc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .ev     (head_ev),
    .q_ctl  (q_ctl),
    .pop    (pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/ptpc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptpc_front
// Accepts event items, decodes the command and drops unknown codes.
// ----------------------------------------------------------------------------
module ptpc_front (
  ptpc_in_if.sink            in_ch,
  output ptpc_pkg::ev_t      ev,
  output logic               ev_push,
  input  logic               q_full
);
  import ptpc_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (in_ch.data.cmd)
      CMD_TICK:  op = OP_TICK;
      CMD_BCAST: op = OP_BCAST;
      CMD_SYNC:  op = OP_SYNC;
      CMD_DRESP: op = OP_DRESP;
      CMD_STATE: op = OP_STATE;
      default:   known = 1'b0;
    endcase
  end

  assign in_ch.ready = !q_full;
  // unknown commands are accepted and vanish here
  assign ev_push     = in_ch.valid && !q_full && known;

  always_comb begin
    ev.op         = op;
    ev.rx         = in_ch.data.rx_time_us;
    ev.tx         = in_ch.data.tx_time_us;
    ev.rt         = in_ch.data.root_time_us;
    ev.id         = in_ch.data.in_sync_id;
    ev.prog_num   = in_ch.data.prog_num;
    ev.pal_num    = in_ch.data.pal_num;
    ev.brightness = in_ch.data.brightness;
    ev.flash      = in_ch.data.flash_req;
    ev.red        = in_ch.data.flash_red;
    ev.green      = in_ch.data.flash_green;
    ev.blue       = in_ch.data.flash_blue;
  end

endmodule
`default_nettype wire

// ----- rtl/ptpc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptpc_queue
// Two-entry FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module ptpc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ptpc_pkg::ev_t      push_ev,
  input  logic               push,
  output logic               full,
  output ptpc_pkg::ev_t      head,
  output ptpc_pkg::qctl_t    ctl,
  input  logic               pop
);
  import ptpc_pkg::*;

  ev_t        mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign head      = mem_r[rptr_r];
  assign ctl.valid = (cnt_r != 2'd0);
  assign ctl.ready = !full;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ev;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ptpc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptpc_back
// Executes events against the link state and drives the result register.
// ----------------------------------------------------------------------------
module ptpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ptpc_pkg::ev_t      ev,
  input  ptpc_pkg::qctl_t    q_ctl,
  output logic               pop,
  ptpc_cfg_if.sink           cfg_ch,
  ptpc_out_if.source         out_ch
);
  import ptpc_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        req_id;
    logic signed [65:0] diff;
    logic               link_up;
    logic [7:0]         prog;
    logic [7:0]         pal;
    logic [7:0]         bright;
    logic               flash;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } res_t;

  link_t              link_r, link_nxt;
  logic [TICK_W-1:0]  quiet_r, quiet_nxt;
  logic [31:0]        timeout_r;
  // t1 - (t2 + t3), kept from the last sync message
  logic signed [65:0] base_r, base_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [7:0]         prog_r, prog_nxt;
  logic [7:0]         pal_r, pal_nxt;
  logic [7:0]         bright_r, bright_nxt;

  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res;
  logic               res_vld;

  logic               exec;
  logic [TICK_W-1:0]  tick_inc;
  logic               expire;
  logic signed [65:0] sync_base;
  logic signed [65:0] dresp_diff;
  logic [63:0]        half;

  assign exec = q_ctl.valid && (!out_valid_r || out_ch.ready);
  assign pop  = exec;

  assign tick_inc  = (quiet_r == TICK_MAX) ? quiet_r : quiet_r + 1'b1;
  assign expire    = CMP_W'(tick_inc) >= CMP_W'(timeout_r);
  assign sync_base = $signed({3'b000, ev.rt}) - $signed({3'b000, ev.rx})
                     - $signed({3'b000, ev.tx});
  assign dresp_diff = base_r + $signed({3'b000, ev.rt});

  // link state
  always_comb begin
    link_nxt = link_r;
    if (exec) begin
      unique case (link_r)
        LINK_DOWN: if (ev.op == OP_BCAST) link_nxt = LINK_UP;
        LINK_UP:   if (ev.op == OP_TICK && expire) link_nxt = LINK_DOWN;
        default:   link_nxt = LINK_DOWN;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    quiet_nxt  = quiet_r;
    base_nxt   = base_r;
    id_nxt     = id_r;
    prog_nxt   = prog_r;
    pal_nxt    = pal_r;
    bright_nxt = bright_r;
    res_vld    = 1'b0;
    res        = '0;
    if (exec) begin
      unique case (link_r)
        LINK_DOWN: begin
          if (ev.op == OP_BCAST) begin
            quiet_nxt = '0;
            res_vld   = 1'b1;
            res.kind  = KIND_ACK;
          end
        end
        LINK_UP: begin
          unique case (ev.op)
            OP_TICK: begin
              if (expire) begin
                quiet_nxt   = '0;
                base_nxt    = '0;
                id_nxt      = '0;
                res_vld     = 1'b1;
                res.kind    = KIND_DISC;
                res.prog    = prog_r;
                res.pal     = pal_r;
                res.bright  = bright_r;
              end else begin
                quiet_nxt = tick_inc;
              end
            end
            OP_SYNC: begin
              quiet_nxt  = '0;
              base_nxt   = sync_base;
              id_nxt     = ev.id;
              res_vld    = 1'b1;
              res.kind   = KIND_DREQ;
              res.req_id = ev.id;
            end
            OP_DRESP: begin
              res_vld = 1'b1;
              if (ev.id != id_r) begin
                res.kind = KIND_MISMATCH;
              end else begin
                res.kind = KIND_OFFSET;
                res.diff = dresp_diff;
              end
            end
            OP_STATE: begin
              quiet_nxt   = '0;
              prog_nxt    = ev.prog_num;
              pal_nxt     = ev.pal_num;
              bright_nxt  = ev.brightness;
              res_vld     = 1'b1;
              res.kind    = KIND_STATE;
              res.link_up = 1'b1;
              res.prog    = ev.prog_num;
              res.pal     = ev.pal_num;
              res.bright  = ev.brightness;
              res.flash   = ev.flash;
              res.red     = ev.red;
              res.green   = ev.green;
              res.blue    = ev.blue;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= LINK_DOWN;
      quiet_r     <= '0;
      timeout_r   <= TIMEOUT_RESET;
      base_r      <= '0;
      id_r        <= '0;
      prog_r      <= PROG_RESET;
      pal_r       <= PAL_RESET;
      bright_r    <= BRIGHT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      link_r      <= link_nxt;
      quiet_r     <= quiet_nxt;
      base_r      <= base_nxt;
      id_r        <= id_nxt;
      prog_r      <= prog_nxt;
      pal_r       <= pal_nxt;
      bright_r    <= bright_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        timeout_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && res_vld) begin
      res_r <= res;
    end
  end

  // halve toward zero: arithmetic shift, plus one for a negative odd value;
  // the halved value always fits 64 bits
  assign half = res_r.diff[64:1] + {63'd0, res_r.diff[65] & res_r.diff[0]};

  assign out_ch.valid = out_valid_r;
  always_comb begin
    out_ch.data.out_kind        = res_r.kind;
    out_ch.data.req_sync_id     = res_r.req_id;
    out_ch.data.offset_us       = $signed(half);
    out_ch.data.link_up         = res_r.link_up;
    out_ch.data.show_program    = res_r.prog;
    out_ch.data.show_palette    = res_r.pal;
    out_ch.data.show_brightness = res_r.bright;
    out_ch.data.show_flash      = res_r.flash;
    out_ch.data.show_red        = res_r.red;
    out_ch.data.show_green      = res_r.green;
    out_ch.data.show_blue       = res_r.blue;
  end

endmodule
`default_nettype wire
